[src/pms_pkg.sv]
// Shared types and constants of the pick motion sequencer.
package pms_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 21;

  localparam logic [31:0] START_DELAY_MS = 32'd100;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_PICK_HEIGHT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_ADJUST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PICK_ANGLE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTEND_WAIT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ADJUST_WAIT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RETRACT_WAIT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_PRESENT = 3'd6;

  // Sequence step codes
  localparam logic [3:0] STEP_START_DELAY = 4'd0;
  localparam logic [3:0] STEP_WAIT_READY  = 4'd1;
  localparam logic [3:0] STEP_EXTEND      = 4'd2;
  localparam logic [3:0] STEP_EXTEND_WAIT = 4'd3;
  localparam logic [3:0] STEP_LIFT        = 4'd4;
  localparam logic [3:0] STEP_LIFT_WAIT   = 4'd5;
  localparam logic [3:0] STEP_SETTLE      = 4'd6;
  localparam logic [3:0] STEP_RETRACT     = 4'd7;
  localparam logic [3:0] STEP_FINAL_WAIT  = 4'd8;

  typedef struct packed {
    logic signed [20:0] pick_z_steps;
    logic signed [16:0] height_adjust_steps;
    logic [8:0]         pick_angle_deg;
    logic [15:0]        extend_wait_ms;
    logic [15:0]        adjust_wait_ms;
    logic [15:0]        retract_wait_ms;
    logic [2:0]         device_present_mask;
  } cfg_t;

  typedef struct packed {
    logic               entered;
    logic               done;
    logic [3:0]         step;
    logic [31:0]        step_start_ms;
    logic signed [20:0] held_height;
  } seq_state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        z_running;
    logic        servo_at_target;
    logic        restart;
  } poll_t;

  typedef struct packed {
    logic               profile_setup;
    logic               z_move;
    logic signed [21:0] z_target;
    logic               servo_move;
    logic [8:0]         angle_cmd;
    logic               fork_extend;
    logic               fork_retract;
    logic               go_place;
    logic [3:0]         step_index;
  } result_t;

endpackage

[src/pms_cfg.sv]
// Configuration register file of the pick motion sequencer.
module pms_cfg
  import pms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pick_z_steps        <= '0;
      cfg_r.height_adjust_steps <= '0;
      cfg_r.pick_angle_deg      <= '0;
      cfg_r.extend_wait_ms      <= 16'd750;
      cfg_r.adjust_wait_ms      <= 16'd100;
      cfg_r.retract_wait_ms     <= 16'd750;
      cfg_r.device_present_mask <= 3'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PICK_HEIGHT:    cfg_r.pick_z_steps        <= cfg_data;
        REG_HEIGHT_ADJUST:  cfg_r.height_adjust_steps <= cfg_data[16:0];
        REG_PICK_ANGLE:     cfg_r.pick_angle_deg      <= cfg_data[8:0];
        REG_EXTEND_WAIT:    cfg_r.extend_wait_ms      <= cfg_data[15:0];
        REG_ADJUST_WAIT:    cfg_r.adjust_wait_ms      <= cfg_data[15:0];
        REG_RETRACT_WAIT:   cfg_r.retract_wait_ms     <= cfg_data[15:0];
        REG_DEVICE_PRESENT: cfg_r.device_present_mask <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

[src/pms_step.sv]
// Next-state and result logic for one poll of the pick sequence.
module pms_step
  import pms_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  poll_t      poll,
  output seq_state_t nxt,
  output result_t    res
);

  logic               has_z, has_servo, has_fork;
  logic [3:0]         step_eff;
  logic [31:0]        start_eff;
  logic               done_eff;
  logic signed [20:0] held_eff;
  logic [31:0]        since_ms;
  logic               z_ok, servo_ok;

  assign has_z     = cfg.device_present_mask[0];
  assign has_servo = cfg.device_present_mask[1];
  assign has_fork  = cfg.device_present_mask[2];

  // Entry poll starts fresh from the current time and the configured pick height
  assign step_eff  = cur.entered ? cur.step : STEP_START_DELAY;
  assign start_eff = cur.entered ? cur.step_start_ms : poll.now_ms;
  assign done_eff  = cur.entered & cur.done;
  assign held_eff  = cur.entered ? cur.held_height : cfg.pick_z_steps;
  assign since_ms  = poll.now_ms - start_eff;
  assign z_ok      = !has_z || !poll.z_running;
  assign servo_ok  = !has_servo || poll.servo_at_target;

  always_comb begin
    nxt = cur;
    res = '0;
    if (poll.restart) begin
      nxt = '0;
    end else begin
      nxt.entered       = 1'b1;
      nxt.done          = done_eff;
      nxt.step          = step_eff;
      nxt.step_start_ms = start_eff;
      nxt.held_height   = held_eff;
      if (!cur.entered) begin
        res.profile_setup = has_z | has_servo;
      end
      if (done_eff) begin
        res.go_place = 1'b1;
      end else begin
        case (step_eff)
          STEP_START_DELAY: begin
            if (since_ms >= START_DELAY_MS) begin
              if (has_z) begin
                res.z_move   = 1'b1;
                res.z_target = {held_eff[20], held_eff};
              end
              if (has_servo) begin
                res.servo_move = 1'b1;
                res.angle_cmd  = cfg.pick_angle_deg;
              end
              nxt.step          = STEP_WAIT_READY;
              nxt.step_start_ms = poll.now_ms;
            end
          end
          STEP_WAIT_READY: begin
            if (z_ok && servo_ok) begin
              nxt.step          = STEP_EXTEND;
              nxt.step_start_ms = poll.now_ms;
            end
          end
          STEP_EXTEND: begin
            res.fork_extend   = has_fork;
            nxt.step          = STEP_EXTEND_WAIT;
            nxt.step_start_ms = poll.now_ms;
          end
          STEP_EXTEND_WAIT: begin
            if (since_ms >= {16'd0, cfg.extend_wait_ms}) begin
              nxt.step          = STEP_LIFT;
              nxt.step_start_ms = poll.now_ms;
            end
          end
          STEP_LIFT: begin
            if (has_z) begin
              res.z_move   = 1'b1;
              res.z_target = {held_eff[20], held_eff}
                + {{5{cfg.height_adjust_steps[16]}}, cfg.height_adjust_steps};
            end
            nxt.step          = STEP_LIFT_WAIT;
            nxt.step_start_ms = poll.now_ms;
          end
          STEP_LIFT_WAIT: begin
            if (z_ok) begin
              nxt.step          = STEP_SETTLE;
              nxt.step_start_ms = poll.now_ms;
            end
          end
          STEP_SETTLE: begin
            if (since_ms >= {16'd0, cfg.adjust_wait_ms}) begin
              nxt.step          = STEP_RETRACT;
              nxt.step_start_ms = poll.now_ms;
            end
          end
          STEP_RETRACT: begin
            res.fork_retract  = has_fork;
            nxt.step          = STEP_FINAL_WAIT;
            nxt.step_start_ms = poll.now_ms;
          end
          STEP_FINAL_WAIT: begin
            if (since_ms >= {16'd0, cfg.retract_wait_ms}) begin
              nxt.done = 1'b1;
            end
          end
          default: begin
            nxt.done = 1'b1;
          end
        endcase
      end
      res.step_index = nxt.step;
    end
  end

endmodule

[src/pick_motion_sequencer_unit.sv]
// Top level of the pick motion sequencer: channels, sequence state, result register.
//
// Usage
//   in_*  : one poll word per item: current millisecond time, Z running flag,
//           servo-at-target flag and a restart flag.
//   out_* : one result word per poll: pulses for profile setup, Z move, servo
//           move, fork extend/retract, the go_place request and the step index.
//   cfg_* : register writes (index, data); always ready, write only while idle.
// Timing: a poll accepted at one edge shows its result on out_* right after
//   that edge. Throughput: one poll per cycle while out_tready is high.
// The sequence state and the result register are updated at the same edge,
//   so the compare and step update set the per-poll cost.
// Reset: sequence goes to not-entered; registers take their defaults
//   (waits 750/100/750 ms, all devices present); no result is pending.
// Stall: while out_tready is low a result is held and in_tready drops; a new
//   poll is taken in the same cycle the held result is consumed.
module pick_motion_sequencer_unit
  import pms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // [31:0] now_ms, [32] z_running, [33] servo_at_target, [34] restart, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] profile_setup, [1] z_move, [23:2] z_target, [24] servo_move,
  // [33:25] angle_cmd, [34] fork_extend, [35] fork_retract, [36] go_place,
  // [40:37] step_index, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  poll_t      poll;
  seq_state_t state_r, state_nxt;
  result_t    res_nxt, res_r;
  logic       out_valid_r;
  logic       in_accept;

  pms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the poll word
  assign poll.now_ms          = in_tdata[31:0];
  assign poll.z_running       = in_tdata[32];
  assign poll.servo_at_target = in_tdata[33];
  assign poll.restart         = in_tdata[34];

  pms_step u_step (
    .cfg  (cfg),
    .cur  (state_r),
    .poll (poll),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Take a new poll whenever the result slot is empty or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.step_index, res_r.go_place, res_r.fork_retract,
                       res_r.fork_extend, res_r.angle_cmd, res_r.servo_move,
                       res_r.z_target, res_r.z_move, res_r.profile_setup};

  // Not-entered sequence always sits at the first step and is not done
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.entered |-> (state_r.step == STEP_START_DELAY) && !state_r.done)
    else $error("not-entered sequence holds stale step or done");

  // Done is only reached from the final wait
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.done |-> state_r.step == STEP_FINAL_WAIT)
    else $error("done set outside final wait step");

  // A restart poll yields an all-zero result
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && poll.restart |=> out_tvalid && (out_tdata == '0))
    else $error("restart poll gave a nonzero result");

  // go_place comes alone, with no motion pulse beside it
  a_place_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.go_place |->
      !res_r.z_move && !res_r.servo_move && !res_r.fork_extend && !res_r.fork_retract)
    else $error("go_place together with a motion pulse");

  // A non-restart poll always leaves the sequence entered
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !poll.restart |=> state_r.entered)
    else $error("poll did not enter the sequence");

endmodule
